/* sv/u8dec_pkg.sv */
`timescale 1ns / 1ps

package u8dec_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned CP_W   = 21;
    localparam int unsigned PEND_W = 2;

    // lead byte range limits
    localparam logic [BYTE_W-1:0] ASCII_MAX = 8'h7f;
    localparam logic [BYTE_W-1:0] LEAD2_MIN = 8'hc0;
    localparam logic [BYTE_W-1:0] LEAD2_MAX = 8'hdf;
    localparam logic [BYTE_W-1:0] LEAD3_MAX = 8'hef;
    localparam logic [BYTE_W-1:0] LEAD4_MAX = 8'hf7;

    // payload masks
    localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'h1f;
    localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'h0f;
    localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'h07;
    localparam logic [BYTE_W-1:0] CONT_MASK  = 8'h3f;

    // continuation bytes still due
    localparam logic [PEND_W-1:0] PEND_NONE  = 2'd0;
    localparam logic [PEND_W-1:0] PEND_ONE   = 2'd1;
    localparam logic [PEND_W-1:0] PEND_TWO   = 2'd2;
    localparam logic [PEND_W-1:0] PEND_THREE = 2'd3;

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            decode_error;
        logic            end_of_buffer;
    } result_t;

endpackage

/* sv/utf8_byte_stream_decoder_unit.sv */
`timescale 1ns / 1ps

// channel | signals                               | transfer when
// --------+---------------------------------------+---------------------------
// src     | src_valid, src_stall, byte_in,        | src_valid && !src_stall
//         | last_byte                             |
// dst     | dst_valid, dst_stall, code_point,     | dst_valid && !dst_stall
//         | decode_error, end_of_buffer           |
//
// one byte per cycle while no result is stalled; a byte is taken into the input
// register, and its result is then decoded into the result register
// reset clears the decode state and both valid flags; no clearing pass
// a stalled result holds the result register; the input register then
// fills and src_stall rises, so at most two bytes sit inside the block

module utf8_byte_stream_decoder_unit
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      src_valid,
    output logic                      src_stall,
    input  logic [u8dec_pkg::BYTE_W-1:0] byte_in,
    input  logic                      last_byte,
    output logic                      dst_valid,
    input  logic                      dst_stall,
    output logic [u8dec_pkg::CP_W-1:0] code_point,
    output logic                      decode_error,
    output logic                      end_of_buffer
);
    import u8dec_pkg::*;

    logic                s1_valid_reg;
    logic [BYTE_W-1:0]   s1_byte_reg;
    logic                s1_last_reg;
    logic [CP_W-1:0]     partial_reg;
    logic [CP_W-1:0]     partial_next;
    logic [PEND_W-1:0]   pending_reg;
    logic [PEND_W-1:0]   pending_next;
    logic                out_valid_reg;
    result_t             out_reg;
    result_t             res_next;
    logic                res_emit;
    logic                out_free;
    logic                s1_fire;
    logic                src_fire;

    // handshake
    assign out_free  = !out_valid_reg || !dst_stall;
    assign s1_fire   = s1_valid_reg && out_free;
    assign src_stall = s1_valid_reg && !out_free;
    assign src_fire  = src_valid && !src_stall;

    // decode of the byte held in the input register
    always_comb
    begin
        partial_next = partial_reg;
        pending_next = pending_reg;
        res_emit     = 1'b0;
        res_next     = '{code_point: '0, decode_error: 1'b0,
                         end_of_buffer: s1_last_reg};
        if (pending_reg == PEND_NONE)
        begin
            priority if (s1_byte_reg <= ASCII_MAX)
            begin
                res_emit            = 1'b1;
                res_next.code_point = CP_W'(s1_byte_reg);
            end
            else if (s1_byte_reg >= LEAD2_MIN && s1_byte_reg <= LEAD2_MAX)
            begin
                partial_next = CP_W'(s1_byte_reg & LEAD2_MASK);
                pending_next = PEND_ONE;
            end
            else if (s1_byte_reg >= LEAD2_MIN && s1_byte_reg <= LEAD3_MAX)
            begin
                partial_next = CP_W'(s1_byte_reg & LEAD3_MASK);
                pending_next = PEND_TWO;
            end
            else if (s1_byte_reg >= LEAD2_MIN && s1_byte_reg <= LEAD4_MAX)
            begin
                partial_next = CP_W'(s1_byte_reg & LEAD4_MASK);
                pending_next = PEND_THREE;
            end
            else
            begin
                // invalid lead byte, state stays
                res_emit              = 1'b1;
                res_next.decode_error = 1'b1;
            end
        end
        else
        begin
            // continuation byte, low six bits only
            partial_next = {partial_reg[CP_W-7:0], s1_byte_reg[5:0]};
            pending_next = pending_reg - PEND_ONE;
            if (pending_next == PEND_NONE)
            begin
                res_emit            = 1'b1;
                res_next.code_point = partial_next;
                partial_next        = '0;
            end
        end

        // sequence cut short by the last byte
        if (!res_emit && s1_last_reg)
        begin
            res_emit              = 1'b1;
            res_next.decode_error = 1'b1;
            partial_next          = '0;
            pending_next          = PEND_NONE;
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (src_fire)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (src_fire)
        begin
            s1_byte_reg <= byte_in;
            s1_last_reg <= last_byte;
        end
    end

    // decode state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_reg <= '0;
            pending_reg <= PEND_NONE;
        end
        else if (s1_fire)
        begin
            partial_reg <= partial_next;
            pending_reg <= pending_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s1_fire && res_emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && res_emit)
        begin
            out_reg <= res_next;
        end
    end

    assign dst_valid     = out_valid_reg;
    assign code_point    = out_reg.code_point;
    assign decode_error  = out_reg.decode_error;
    assign end_of_buffer = out_reg.end_of_buffer;

    // checks
    a_err_zero_cp: assert property (@(posedge clk) disable iff (!rst_n)
        dst_valid && decode_error |-> code_point == '0)
        else $error("error result carries a nonzero code point");

    a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && s1_last_reg |=> pending_reg == PEND_NONE)
        else $error("sequence still open after the last byte");

    a_last_emits: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && s1_last_reg |=> dst_valid && end_of_buffer)
        else $error("last byte gave no end-of-buffer result");

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        src_stall |-> s1_valid_reg && dst_valid)
        else $error("input stalled with room inside");

endmodule
